// ===== rtl/crc_checked_frame_deframer_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, checked out of reset
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== rtl/cfd_pkg.sv =====
// shared types, constants and functions of the crc checked frame deframer
package cfd_pkg;

    // largest frame (payload plus framing overhead) that fits the receive ring
    localparam int RING_BYTES = 256;
    localparam int FRAME_OVERHEAD = 8;

    // framing bytes
    localparam logic [7:0] SYNC_A = 8'hAB;
    localparam logic [7:0] SYNC_B = 8'hCD;
    localparam logic [7:0] FOOT_A = 8'hDC;
    localparam logic [7:0] FOOT_B = 8'hBA;

    // mode select pairs, first byte then second byte
    localparam logic [7:0] MODE_CLR_0 = 8'h14;
    localparam logic [7:0] MODE_CLR_1 = 8'h05;
    localparam logic [7:0] MODE_OBF_0 = 8'h02;
    localparam logic [7:0] MODE_OBF_1 = 8'h69;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] XOR_KEY [16] = '{
        8'h16, 8'h6C, 8'h14, 8'hE6, 8'h2E, 8'h91, 8'h0D, 8'h40,
        8'h21, 8'h35, 8'hD5, 8'h40, 8'h13, 8'h03, 8'hE9, 8'h80
    };

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_FOOT_ERR = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // receive phases
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_PAYLOAD = 4'd4,
        PH_CRC_LO  = 4'd5,
        PH_CRC_HI  = 4'd6,
        PH_FOOT1   = 4'd7,
        PH_FOOT2   = 4'd8
    } t_phase;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] frame_status;
        logic       obfuscated;
        logic       last;
    } t_result;

    // crc16 xmodem, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // remove the key when the frame is obfuscated
    function automatic logic [7:0] unmask(input logic [7:0] b, input logic mode,
                                          input logic [3:0] pos);
        return mode ? (b ^ XOR_KEY[pos]) : b;
    endfunction

endpackage

// ===== rtl/cfd_core.sv =====
// frame parser: phase tracking, de-obfuscation, crc and status generation
`include "crc_checked_frame_deframer_assert.svh"

module cfd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic [1:0]       o_push,
    output cfd_pkg::t_result o_res0,
    output cfd_pkg::t_result o_res1
);

    cfd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_running_crc, n_running_crc;
    logic [15:0] r_crc_clear, n_crc_clear;
    logic [7:0]  r_rx_crc_low, n_rx_crc_low;
    logic [7:0]  r_held_byte, n_held_byte;
    logic        r_obf_on, n_obf_on;
    logic        r_frame_mode, n_frame_mode;
    logic        r_crc_mismatch, n_crc_mismatch;
    logic        r_foot1_ok, n_foot1_ok;

    logic [15:0] len_full;
    logic        too_long;
    logic [16:0] count_inc;
    logic        mode_dec;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [15:0] crc_base;
    logic [15:0] rx_crc;
    logic        foot_good;

    // shared decode terms
    always_comb begin
        len_full  = {i_byte, r_frame_length[7:0]};
        too_long  = ({2'b00, len_full} + 18'(cfd_pkg::FRAME_OVERHEAD))
                    > 18'(cfd_pkg::RING_BYTES);
        count_inc = {1'b0, r_byte_count} + 17'd1;
        if (r_held_byte == cfd_pkg::MODE_CLR_0 && i_byte == cfd_pkg::MODE_CLR_1) begin
            mode_dec = 1'b0;
        end else if (r_held_byte == cfd_pkg::MODE_OBF_0 && i_byte == cfd_pkg::MODE_OBF_1) begin
            mode_dec = 1'b1;
        end else begin
            mode_dec = r_frame_mode;
        end
        c0        = cfd_pkg::unmask(r_held_byte, mode_dec, 4'd0);
        c1        = cfd_pkg::unmask(i_byte, mode_dec, 4'd1);
        crc_base  = mode_dec ? r_running_crc : r_crc_clear;
        rx_crc    = {cfd_pkg::unmask(i_byte, r_frame_mode, r_frame_length[3:0] + 4'd1),
                     r_rx_crc_low};
        foot_good = r_foot1_ok && (i_byte == cfd_pkg::FOOT_B);
    end

    // next state and results
    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;
        n_running_crc  = r_running_crc;
        n_crc_clear    = r_crc_clear;
        n_rx_crc_low   = r_rx_crc_low;
        n_held_byte    = r_held_byte;
        n_obf_on       = r_obf_on;
        n_frame_mode   = r_frame_mode;
        n_crc_mismatch = r_crc_mismatch;
        n_foot1_ok     = r_foot1_ok;
        o_push         = 2'd0;
        o_res0         = '0;
        o_res1         = '0;
        if (i_fire) begin
            case (r_phase)
                cfd_pkg::PH_SYNC2: begin
                    if (i_byte == cfd_pkg::SYNC_B) begin
                        n_phase = cfd_pkg::PH_LEN_LO;
                    end else if (i_byte != cfd_pkg::SYNC_A) begin
                        n_phase = cfd_pkg::PH_HUNT;
                    end
                end
                cfd_pkg::PH_LEN_LO: begin
                    n_frame_length = {8'h00, i_byte};
                    n_phase        = cfd_pkg::PH_LEN_HI;
                end
                cfd_pkg::PH_LEN_HI: begin
                    n_frame_length = len_full;
                    n_frame_mode   = r_obf_on;
                    n_byte_count   = 16'd0;
                    n_running_crc  = 16'd0;
                    n_crc_mismatch = 1'b0;
                    n_foot1_ok     = 1'b0;
                    if (too_long) begin
                        o_push = 2'd1;
                        o_res0 = '{kind: cfd_pkg::KIND_STATUS, data_byte: 8'h00,
                                   frame_status: cfd_pkg::ST_TOO_LONG,
                                   obfuscated: r_obf_on, last: 1'b1};
                        n_phase = cfd_pkg::PH_HUNT;
                    end else if (len_full != 16'd0) begin
                        n_phase = cfd_pkg::PH_PAYLOAD;
                    end else begin
                        n_phase = cfd_pkg::PH_CRC_LO;
                    end
                end
                cfd_pkg::PH_PAYLOAD: begin
                    if (r_byte_count == 16'd0 && r_frame_length >= 16'd2) begin
                        // hold the first byte, precompute its crc for both modes
                        n_held_byte   = i_byte;
                        n_crc_clear   = cfd_pkg::crc_update(16'd0, i_byte);
                        n_running_crc = cfd_pkg::crc_update(16'd0,
                                            i_byte ^ cfd_pkg::XOR_KEY[0]);
                    end else if (r_byte_count == 16'd1) begin
                        n_frame_mode  = mode_dec;
                        n_running_crc = cfd_pkg::crc_update(crc_base, c1);
                        o_push = 2'd2;
                        o_res0 = '{kind: cfd_pkg::KIND_DATA, data_byte: c0,
                                   frame_status: cfd_pkg::ST_OK,
                                   obfuscated: mode_dec, last: 1'b0};
                        o_res1 = '{kind: cfd_pkg::KIND_DATA, data_byte: c1,
                                   frame_status: cfd_pkg::ST_OK,
                                   obfuscated: mode_dec, last: 1'b0};
                    end else begin
                        o_push = 2'd1;
                        o_res0 = '{kind: cfd_pkg::KIND_DATA,
                                   data_byte: cfd_pkg::unmask(i_byte, r_frame_mode,
                                                              r_byte_count[3:0]),
                                   frame_status: cfd_pkg::ST_OK,
                                   obfuscated: r_frame_mode, last: 1'b0};
                        n_running_crc = cfd_pkg::crc_update(r_running_crc, o_res0.data_byte);
                    end
                    n_byte_count = count_inc[15:0];
                    if (count_inc >= {1'b0, r_frame_length}) begin
                        n_phase = cfd_pkg::PH_CRC_LO;
                    end
                end
                cfd_pkg::PH_CRC_LO: begin
                    n_rx_crc_low = cfd_pkg::unmask(i_byte, r_frame_mode, r_frame_length[3:0]);
                    n_phase      = cfd_pkg::PH_CRC_HI;
                end
                cfd_pkg::PH_CRC_HI: begin
                    n_crc_mismatch = (rx_crc != r_running_crc);
                    n_phase        = cfd_pkg::PH_FOOT1;
                end
                cfd_pkg::PH_FOOT1: begin
                    n_foot1_ok = (i_byte == cfd_pkg::FOOT_A);
                    n_phase    = cfd_pkg::PH_FOOT2;
                end
                cfd_pkg::PH_FOOT2: begin
                    if (foot_good) begin
                        n_obf_on = r_frame_mode;
                    end
                    o_push = 2'd1;
                    o_res0 = '{kind: cfd_pkg::KIND_STATUS, data_byte: 8'h00,
                               frame_status: !foot_good ? cfd_pkg::ST_FOOT_ERR :
                                   (r_crc_mismatch ? cfd_pkg::ST_CRC_ERR : cfd_pkg::ST_OK),
                               obfuscated: r_frame_mode, last: 1'b1};
                    n_phase = cfd_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = (i_byte == cfd_pkg::SYNC_A) ? cfd_pkg::PH_SYNC2
                                                          : cfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= cfd_pkg::PH_HUNT;
            r_frame_length <= 16'd0;
            r_byte_count   <= 16'd0;
            r_running_crc  <= 16'd0;
            r_crc_clear    <= 16'd0;
            r_rx_crc_low   <= 8'd0;
            r_held_byte    <= 8'd0;
            r_obf_on       <= 1'b1;
            r_frame_mode   <= 1'b1;
            r_crc_mismatch <= 1'b0;
            r_foot1_ok     <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_running_crc  <= n_running_crc;
            r_crc_clear    <= n_crc_clear;
            r_rx_crc_low   <= n_rx_crc_low;
            r_held_byte    <= n_held_byte;
            r_obf_on       <= n_obf_on;
            r_frame_mode   <= n_frame_mode;
            r_crc_mismatch <= n_crc_mismatch;
            r_foot1_ok     <= n_foot1_ok;
        end
    end

    // a pair of results only comes from the second payload byte
    `CFD_ASSERT_IMPL(a_pair_on_second, i_clk, i_rst_n, o_push == 2'd2,
        r_phase == cfd_pkg::PH_PAYLOAD && r_byte_count == 16'd1)
    // every status result returns the parser to the hunt
    `CFD_ASSERT_NEXT(a_status_to_hunt, i_clk, i_rst_n,
        o_push == 2'd1 && o_res0.kind == cfd_pkg::KIND_STATUS, r_phase == cfd_pkg::PH_HUNT)
    // the sticky mode only moves on a frame footer
    `CFD_ASSERT_IMPL(a_sticky_on_footer, i_clk, i_rst_n, !$stable(r_obf_on),
        $past(r_phase) == cfd_pkg::PH_FOOT2 && $past(i_fire))

endmodule

// ===== rtl/cfd_out_fifo.sv =====
// four-entry result queue taking up to two results per cycle while two entries are free
`include "crc_checked_frame_deframer_assert.svh"

module cfd_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  cfd_pkg::t_result i_res0,
    input  cfd_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output cfd_pkg::t_result o_head
);

    cfd_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop_ok;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push;
        n_rd_ptr = r_rd_ptr + {1'b0, pop_ok};
        n_count  = r_count + {1'b0, i_push} - {2'b00, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

    // pushes only arrive when two entries are free
    `CFD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push != 2'd0, o_room)
    // fill count stays within the queue
    `CFD_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 3'd4)
    // pointers agree with the fill count
    `CFD_ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n, r_count != 3'd4,
        (r_wr_ptr - r_rd_ptr) == r_count[1:0])
    // a result pushed into an empty queue shows next cycle
    `CFD_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push != 2'd0, o_valid)

endmodule

// ===== rtl/crc_checked_frame_deframer.sv =====
// top level of the crc checked frame deframer
//
// Input channel: one received byte per request on i_rx_byte, taken at a rising
// edge with i_valid high and o_stall low. Output channel: one result per request
// (payload byte or end-of-frame status), taken with o_valid high and i_stall low.
// A byte is held in an input register, parsed once the queue has room, and its
// results go to a four-entry result queue. The first payload byte of a frame of
// two or more bytes is pushed to the queue together with the second. While the
// input does not stall, one byte is taken every cycle; the second payload byte
// of a frame puts two results in the queue, but the sync and length bytes of a
// frame that fits give none, so a queue drained every cycle never holds more
// than two results and the input does not stall then.
// The input stalls while the queue holds more than two results and a byte waits
// in the input register; a stalled output simply holds its head result.
// Reset (synchronous, active low) empties the input register and the queue,
// puts the parser in the sync hunt and turns the sticky obfuscation mode on.
module crc_checked_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_frame_status,
    output logic       o_obfuscated,
    output logic       o_last
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             in_fire;
    logic             proc_fire;
    logic             fifo_room;
    logic [1:0]       push;
    cfd_pkg::t_result res0;
    cfd_pkg::t_result res1;
    cfd_pkg::t_result head;

    // input register handshake
    assign proc_fire  = r_in_valid && fifo_room;
    assign o_stall    = r_in_valid && !fifo_room;
    assign in_fire    = i_valid && !o_stall;
    assign n_in_valid = in_fire || (r_in_valid && !proc_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser
    cfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_byte  (r_in_byte),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue
    cfd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (!i_stall),
        .o_room  (fifo_room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    // output fields
    assign o_kind         = head.kind;
    assign o_data_byte    = head.data_byte;
    assign o_frame_status = head.frame_status;
    assign o_obfuscated   = head.obfuscated;
    assign o_last         = head.last;

endmodule

// ===== sim/crc_checked_frame_deframer_tb.sv =====
// self-checking testbench of the crc checked frame deframer
`timescale 1ns / 1ps

module crc_checked_frame_deframer_tb;

    localparam int MAX_LEN     = cfd_pkg::RING_BYTES - cfd_pkg::FRAME_OVERHEAD;
    localparam int ITEM_TARGET = 950;
    localparam int PHASE_SPAN  = 96;
    localparam int BUSY_PCT    = 68;
    localparam int LIGHT_PCT   = 6;
    localparam int HOLD_CYCLES = 60;
    localparam int WDOG_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 20;

    // how a generated frame picks its mode
    typedef enum int {
        SEL_KEEP,
        SEL_CLEAR,
        SEL_OBF
    } t_mode_sel;

    // which footer byte a generated frame corrupts
    typedef enum int {
        FOOT_GOOD,
        FOOT_BAD_FIRST,
        FOOT_BAD_SECOND
    } t_foot_err;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_kind;
    logic [7:0] o_data_byte;
    logic [1:0] o_frame_status;
    logic       o_obfuscated;
    logic       o_last;

    crc_checked_frame_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_status (o_frame_status),
        .o_obfuscated   (o_obfuscated),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // byte stream waiting to be sent and results still owed by the block
    logic [7:0]       rx_stream_q[$];
    cfd_pkg::t_result frame_results_q[$];

    int sent_cnt = 0;
    int taken_cnt = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int holds_done = 0;

    // deframer state as predicted
    cfd_pkg::t_phase dfm_phase = cfd_pkg::PH_HUNT;
    logic [15:0] dfm_len = '0;
    logic [15:0] dfm_count = '0;
    logic [15:0] dfm_crc = '0;
    logic [7:0]  dfm_crc_lo = '0;
    logic [7:0]  dfm_held = '0;
    logic        dfm_sticky = 1'b1;
    logic        dfm_mode = 1'b1;
    logic        dfm_crc_bad = 1'b0;
    logic        dfm_foot1_ok = 1'b0;

    // sticky mode as the frame generator expects it
    logic gen_sticky = 1'b1;

    // crc16 xmodem over one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ cfd_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // apply or remove the key at a payload position
    function automatic logic [7:0] keyed_byte(input logic [7:0] b, input logic mode,
                                              input logic [15:0] pos);
        return mode ? (b ^ cfd_pkg::XOR_KEY[pos[3:0]]) : b;
    endfunction

    task automatic push_result(input logic kind, input logic [7:0] data,
                               input logic [1:0] st, input logic obf);
        cfd_pkg::t_result r;
        r.kind = kind;
        r.data_byte = data;
        r.frame_status = st;
        r.obfuscated = obf;
        r.last = (kind == cfd_pkg::KIND_STATUS);
        frame_results_q.push_back(r);
    endtask

    // advance the predicted deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [15:0] rx_crc;
        logic        good;
        case (dfm_phase)
            cfd_pkg::PH_SYNC2: begin
                if (b == cfd_pkg::SYNC_B) begin
                    dfm_phase = cfd_pkg::PH_LEN_LO;
                end else if (b != cfd_pkg::SYNC_A) begin
                    dfm_phase = cfd_pkg::PH_HUNT;
                end
            end
            cfd_pkg::PH_LEN_LO: begin
                dfm_len = {8'h00, b};
                dfm_phase = cfd_pkg::PH_LEN_HI;
            end
            cfd_pkg::PH_LEN_HI: begin
                dfm_len[15:8] = b;
                dfm_mode = dfm_sticky;
                dfm_count = '0;
                dfm_crc = '0;
                dfm_crc_bad = 1'b0;
                dfm_foot1_ok = 1'b0;
                if (int'(dfm_len) + cfd_pkg::FRAME_OVERHEAD > cfd_pkg::RING_BYTES) begin
                    push_result(cfd_pkg::KIND_STATUS, 8'h00, cfd_pkg::ST_TOO_LONG, dfm_mode);
                    dfm_phase = cfd_pkg::PH_HUNT;
                end else begin
                    dfm_phase = (dfm_len != 0) ? cfd_pkg::PH_PAYLOAD : cfd_pkg::PH_CRC_LO;
                end
            end
            cfd_pkg::PH_PAYLOAD: begin
                if (dfm_count == 0 && dfm_len >= 2) begin
                    dfm_held = b;
                end else if (dfm_count == 1) begin
                    // second byte decides the mode of the frame
                    if (dfm_held == cfd_pkg::MODE_CLR_0 && b == cfd_pkg::MODE_CLR_1) begin
                        dfm_mode = 1'b0;
                    end else if (dfm_held == cfd_pkg::MODE_OBF_0 &&
                                 b == cfd_pkg::MODE_OBF_1) begin
                        dfm_mode = 1'b1;
                    end
                    c0 = keyed_byte(dfm_held, dfm_mode, 16'd0);
                    c1 = keyed_byte(b, dfm_mode, 16'd1);
                    dfm_crc = crc16_step(crc16_step(dfm_crc, c0), c1);
                    push_result(cfd_pkg::KIND_DATA, c0, cfd_pkg::ST_OK, dfm_mode);
                    push_result(cfd_pkg::KIND_DATA, c1, cfd_pkg::ST_OK, dfm_mode);
                end else begin
                    c0 = keyed_byte(b, dfm_mode, dfm_count);
                    dfm_crc = crc16_step(dfm_crc, c0);
                    push_result(cfd_pkg::KIND_DATA, c0, cfd_pkg::ST_OK, dfm_mode);
                end
                dfm_count = dfm_count + 16'd1;
                if (dfm_count >= dfm_len) begin
                    dfm_phase = cfd_pkg::PH_CRC_LO;
                end
            end
            cfd_pkg::PH_CRC_LO: begin
                dfm_crc_lo = keyed_byte(b, dfm_mode, dfm_len);
                dfm_phase = cfd_pkg::PH_CRC_HI;
            end
            cfd_pkg::PH_CRC_HI: begin
                rx_crc = {keyed_byte(b, dfm_mode, dfm_len + 16'd1), dfm_crc_lo};
                dfm_crc_bad = (rx_crc != dfm_crc);
                dfm_phase = cfd_pkg::PH_FOOT1;
            end
            cfd_pkg::PH_FOOT1: begin
                dfm_foot1_ok = (b == cfd_pkg::FOOT_A);
                dfm_phase = cfd_pkg::PH_FOOT2;
            end
            cfd_pkg::PH_FOOT2: begin
                // footer error wins over crc error, mode commits on a good footer
                good = dfm_foot1_ok && (b == cfd_pkg::FOOT_B);
                if (good) begin
                    dfm_sticky = dfm_mode;
                end
                push_result(cfd_pkg::KIND_STATUS, 8'h00,
                            !good ? cfd_pkg::ST_FOOT_ERR :
                                (dfm_crc_bad ? cfd_pkg::ST_CRC_ERR : cfd_pkg::ST_OK),
                            dfm_mode);
                dfm_phase = cfd_pkg::PH_HUNT;
            end
            default: begin
                dfm_phase = (b == cfd_pkg::SYNC_A) ? cfd_pkg::PH_SYNC2 : cfd_pkg::PH_HUNT;
            end
        endcase
    endtask

    // queue one complete frame with random payload
    task automatic add_frame(input int len, input t_mode_sel sel, input bit bad_crc,
                             input t_foot_err foot_err, input int extra_sync);
        logic [7:0]  raw[$];
        logic        fmode;
        logic [15:0] acc;
        logic [15:0] len16;
        len16 = 16'(len);
        for (int i = 0; i < len; i++) begin
            raw.push_back(8'($urandom_range(255)));
        end
        if (len >= 2 && sel == SEL_CLEAR) begin
            raw[0] = cfd_pkg::MODE_CLR_0;
            raw[1] = cfd_pkg::MODE_CLR_1;
        end else if (len >= 2 && sel == SEL_OBF) begin
            raw[0] = cfd_pkg::MODE_OBF_0;
            raw[1] = cfd_pkg::MODE_OBF_1;
        end
        fmode = gen_sticky;
        if (len >= 2 && raw[0] == cfd_pkg::MODE_CLR_0 &&
            raw[1] == cfd_pkg::MODE_CLR_1) begin
            fmode = 1'b0;
        end else if (len >= 2 && raw[0] == cfd_pkg::MODE_OBF_0 &&
                     raw[1] == cfd_pkg::MODE_OBF_1) begin
            fmode = 1'b1;
        end
        acc = '0;
        for (int i = 0; i < len; i++) begin
            acc = crc16_step(acc, keyed_byte(raw[i], fmode, 16'(i)));
        end
        if (bad_crc) begin
            acc = acc ^ (16'h0001 << $urandom_range(15));
        end
        repeat (extra_sync) rx_stream_q.push_back(cfd_pkg::SYNC_A);
        rx_stream_q.push_back(cfd_pkg::SYNC_A);
        rx_stream_q.push_back(cfd_pkg::SYNC_B);
        rx_stream_q.push_back(len16[7:0]);
        rx_stream_q.push_back(len16[15:8]);
        foreach (raw[i]) rx_stream_q.push_back(raw[i]);
        rx_stream_q.push_back(keyed_byte(acc[7:0], fmode, len16));
        rx_stream_q.push_back(keyed_byte(acc[15:8], fmode, len16 + 16'd1));
        rx_stream_q.push_back(foot_err == FOOT_BAD_FIRST ?
                              cfd_pkg::FOOT_A ^ 8'($urandom_range(1, 255)) :
                              cfd_pkg::FOOT_A);
        rx_stream_q.push_back(foot_err == FOOT_BAD_SECOND ?
                              cfd_pkg::FOOT_B ^ 8'($urandom_range(1, 255)) :
                              cfd_pkg::FOOT_B);
        if (foot_err == FOOT_GOOD) begin
            gen_sticky = fmode;
        end
    endtask

    // header whose length does not fit the ring
    task automatic add_too_long(input int len);
        logic [15:0] len16;
        len16 = 16'(len);
        rx_stream_q.push_back(cfd_pkg::SYNC_A);
        rx_stream_q.push_back(cfd_pkg::SYNC_B);
        rx_stream_q.push_back(len16[7:0]);
        rx_stream_q.push_back(len16[15:8]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) rx_stream_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
        end
    endtask

    // idling pattern follows the number of bytes sent so far
    function automatic int send_idle_pct(input int n);
        case ((n / PHASE_SPAN) % 4)
            1: return BUSY_PCT;
            3: return LIGHT_PCT;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int n);
        case ((n / PHASE_SPAN) % 4)
            2: return BUSY_PCT;
            3: return LIGHT_PCT;
            default: return 0;
        endcase
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_rx_byte <= 8'h00;
        end else if (!i_valid || !o_stall) begin
            if (rx_stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct(sent_cnt)) begin
                i_valid <= 1'b1;
                i_rx_byte <= rx_stream_q.pop_front();
                sent_cnt++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver, with long hold-offs to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && taken_cnt >= 250 + 400 * holds_done) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct(sent_cnt));
        end
    end

    // monitor: predict on accepted bytes, check accepted results
    always @(posedge i_clk) begin
        cfd_pkg::t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                deframe_byte(i_rx_byte);
                taken_cnt++;
            end
            if (o_valid && !i_stall) begin
                if (frame_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got kind %0h data %0h",
                             $time, o_kind, o_data_byte);
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data_byte, o_data_byte);
                    check_field("frame_status", want.frame_status, o_frame_status);
                    check_field("obfuscated", want.obfuscated, o_obfuscated);
                    check_field("last", want.last, o_last);
                end
            end
            // watchdog on a stuck handshake
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WDOG_LIMIT) begin
                    $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
                    $display("[crc_checked_frame_deframer] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        // directed frames: empty, single byte, mode switches, errors, extremes
        add_frame(0, SEL_KEEP, 0, FOOT_GOOD, 1);
        add_frame(1, SEL_KEEP, 0, FOOT_GOOD, 0);
        add_frame(2, SEL_CLEAR, 0, FOOT_GOOD, 0);
        add_frame(5, SEL_KEEP, 0, FOOT_GOOD, 2);
        add_frame(4, SEL_OBF, 0, FOOT_BAD_SECOND, 0);
        add_frame(3, SEL_KEEP, 0, FOOT_GOOD, 0);
        add_frame(6, SEL_OBF, 1, FOOT_GOOD, 0);
        add_frame(20, SEL_KEEP, 0, FOOT_GOOD, 0);
        add_too_long(MAX_LEN + 1);
        add_too_long(16'hFFFF);
        add_frame(MAX_LEN, SEL_KEEP, 0, FOOT_GOOD, 0);
        rx_stream_q.push_back(8'h00);
        rx_stream_q.push_back(8'hFF);
        rx_stream_q.push_back(cfd_pkg::SYNC_B);
        rx_stream_q.push_back(cfd_pkg::SYNC_A);
        rx_stream_q.push_back(8'h00);
        add_frame(1, SEL_KEEP, 1, FOOT_GOOD, 0);
        add_frame(3, SEL_CLEAR, 0, FOOT_BAD_FIRST, 0);
        add_frame(2, SEL_CLEAR, 1, FOOT_GOOD, 0);
        add_frame(0, SEL_KEEP, 0, FOOT_GOOD, 0);
        add_frame(4, SEL_OBF, 1, FOOT_BAD_FIRST, 0);
        add_frame(17, SEL_KEEP, 0, FOOT_GOOD, 0);

        // random frames, mostly well formed, some broken, some noise between
        while (rx_stream_q.size() < ITEM_TARGET) begin
            case ($urandom_range(49))
                0, 1: add_too_long($urandom_range(MAX_LEN + 1, 65535));
                2: add_frame($urandom_range(13, MAX_LEN), t_mode_sel'($urandom_range(2)),
                             0, FOOT_GOOD, 0);
                default: add_frame($urandom_range(0, 12), t_mode_sel'($urandom_range(2)),
                                   $urandom_range(9) == 0,
                                   ($urandom_range(9) == 0) ?
                                       t_foot_err'($urandom_range(1, 2)) : FOOT_GOOD,
                                   ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
            endcase
            if ($urandom_range(4) == 0) begin
                add_noise($urandom_range(1, 4));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all bytes taken, all results seen, then a short quiet tail
        @(negedge i_clk);
        while (rx_stream_q.size() != 0 || i_valid) @(negedge i_clk);
        while (frame_results_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0 && frame_results_q.size() == 0) begin
            $display("[crc_checked_frame_deframer] OK");
        end else begin
            $display("[crc_checked_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
